// File: sv/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg: shared types and constants of the fraction reduce/compare unit
// item layouts, operation codes and the reduced fraction record
// ----------------------------------------------------------------------------
package frc_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);
	localparam int PROD_W      = 2 * VALUE_WIDTH - 1;

	localparam logic [VALUE_WIDTH-2:0] DEN_MAX = '1;
	localparam logic [VALUE_WIDTH-1:0] MAG_MAX = {1'b0, DEN_MAX};

	typedef enum logic {
		OP_REDUCE  = 1'b0,
		OP_COMPARE = 1'b1
	} op_t;

	typedef struct packed {
		logic                          operation;
		logic signed [VALUE_WIDTH-1:0] num_a;
		logic signed [VALUE_WIDTH-1:0] den_a;
		logic signed [VALUE_WIDTH-1:0] num_b;
		logic signed [VALUE_WIDTH-1:0] den_b;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] reduced_num;
		logic        [VALUE_WIDTH-2:0] reduced_den;
		logic                          is_less;
		logic                          is_equal;
	} out_item_t;

	// reduced fraction: sign flag, numerator magnitude, denominator
	typedef struct packed {
		logic                   neg;
		logic [VALUE_WIDTH-1:0] num;
		logic [VALUE_WIDTH-2:0] den;
	} frac_t;

endpackage

// File: sv/frc_reduce.sv
// ----------------------------------------------------------------------------
// frc_reduce: reduces one signed fraction to lowest terms
// binary gcd, then two restoring divisions, all on one shared subtractor
// ----------------------------------------------------------------------------
module frc_reduce import frc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] num_raw,
	input  logic [VALUE_WIDTH-1:0] den_raw,
	output logic                   done,
	output frac_t                  res
);

	localparam int W = VALUE_WIDTH;

	typedef enum logic [4:0] {
		R_IDLE = 5'b00001,
		R_GCD  = 5'b00010,
		R_DIVN = 5'b00100,
		R_DIVD = 5'b01000,
		R_DONE = 5'b10000
	} rstate_t;

	rstate_t          state_q;
	logic             nneg_q, dneg_q;
	logic [W-1:0]     mn_q, md_q, qn_q;
	logic [W-1:0]     a_q, b_q, g_q;
	logic [W-1:0]     rem_q, quo_q;
	logic [CNT_W-1:0] k_q, cnt_q;

	logic [W:0]       sub_x, sub_y;
	logic [W+1:0]     sub_r;
	logic             borrow;
	logic [W-1:0]     gcd_val, quo_next, rem_next;
	logic             mn_big;

	// shared subtractor
	always_comb begin
		if (state_q == R_GCD) begin
			sub_x = {1'b0, a_q};
			sub_y = {1'b0, b_q};
		end else begin
			sub_x = {rem_q, quo_q[W-1]};
			sub_y = {1'b0, g_q};
		end
	end

	assign sub_r    = {1'b0, sub_x} - {1'b0, sub_y};
	assign borrow   = sub_r[W+1];
	assign gcd_val  = (a_q | b_q) << k_q;
	assign quo_next = {quo_q[W-2:0], ~borrow};
	assign rem_next = borrow ? sub_x[W-1:0] : sub_r[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
		end else begin
			case (state_q)
				R_IDLE, R_DONE: begin
					if (start) begin
						state_q <= R_GCD;
					end else begin
						state_q <= R_IDLE;
					end
				end
				R_GCD: begin
					if (a_q == '0 || b_q == '0) begin
						state_q <= (gcd_val == '0) ? R_DONE : R_DIVN;
					end
				end
				R_DIVN: begin
					if (cnt_q == CNT_W'(W - 1)) begin
						state_q <= R_DIVD;
					end
				end
				R_DIVD: begin
					if (cnt_q == CNT_W'(W - 1)) begin
						state_q <= R_DONE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE, R_DONE: begin
				if (start) begin
					nneg_q <= num_raw[W-1];
					dneg_q <= den_raw[W-1];
					mn_q   <= num_raw[W-1] ? W'(0) - num_raw : num_raw;
					md_q   <= den_raw[W-1] ? W'(0) - den_raw : den_raw;
					a_q    <= num_raw[W-1] ? W'(0) - num_raw : num_raw;
					b_q    <= den_raw[W-1] ? W'(0) - den_raw : den_raw;
					k_q    <= '0;
				end
			end
			R_GCD: begin
				if (a_q == '0 || b_q == '0) begin
					g_q   <= gcd_val;
					rem_q <= '0;
					quo_q <= mn_q;
					cnt_q <= '0;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (borrow) begin
					a_q <= b_q;
					b_q <= a_q;
				end else begin
					a_q <= sub_r[W-1:0];
				end
			end
			R_DIVN: begin
				if (cnt_q == CNT_W'(W - 1)) begin
					qn_q  <= quo_next;
					rem_q <= '0;
					quo_q <= md_q;
					cnt_q <= '0;
				end else begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			R_DIVD: begin
				if (cnt_q == CNT_W'(W - 1)) begin
					mn_q <= qn_q;
					md_q <= quo_next;
				end else begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// sign placement and saturation
	always_comb begin
		res.neg = (nneg_q != dneg_q) && mn_q != '0 && md_q != '0;
		res.den = md_q[W-1] ? DEN_MAX : md_q[W-2:0];
		mn_big  = !res.neg && mn_q[W-1];
		res.num = mn_big ? MAG_MAX : mn_q;
	end

	assign done = (state_q == R_DONE);

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("reduce sequencer state not one-hot");

	a_no_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(res.neg && res.num == '0))
		else $error("negative zero numerator");

	a_zero_num_den: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.num == '0) |-> res.den <= 1)
		else $error("zero numerator with denominator above one");

endmodule

// File: sv/fraction_reduce_compare.sv
// ----------------------------------------------------------------------------
// fraction_reduce_compare: signed rational reduce and compare unit
// reduces a fraction to lowest terms, or compares two reduced fractions
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready/in_data) takes one item; operation selects
//   reduce of num_a/den_a, or compare of the first fraction against the second
//   out channel (out_valid/out_ready/out_data) returns one item per input item
//   each fraction goes through one reduce unit: a binary gcd, then two
//   bit-serial divisions, all on one shared subtractor; 0/0 skips the divisions
//   compare: two reductions back to back, then the two cross products in turn
//   on one multiplier, then the final compare
//   in_ready is high only while the sequencer is idle; one item at a time
//   the result sits in an output register, so a stalled receiver holds at
//   most one result while the next item is already being worked on
//   reset clears the sequencer and the output valid flag
// ----------------------------------------------------------------------------
module fraction_reduce_compare import frc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int W = VALUE_WIDTH;

	typedef enum logic [5:0] {
		T_IDLE  = 6'b000001,
		T_RED_A = 6'b000010,
		T_RED_B = 6'b000100,
		T_MUL_L = 6'b001000,
		T_MUL_R = 6'b010000,
		T_FIN   = 6'b100000
	} tstate_t;

	tstate_t         state_q;
	in_item_t        item_q;
	frac_t           fa_q, fb_q;
	logic [PROD_W-1:0] lprod_q, rprod_q;
	logic            out_valid_q;
	out_item_t       out_data_q;

	logic            red_start, red_done;
	logic [W-1:0]    red_num, red_den;
	frac_t           red_res;
	logic [W-1:0]    mul_x;
	logic [W-2:0]    mul_y;
	logic [PROD_W-1:0] mul_p;
	logic            accept, load_out;
	logic            lneg, rneg, less, equal, cmp_op;

	frc_reduce u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (red_start),
		.num_raw (red_num),
		.den_raw (red_den),
		.done    (red_done),
		.res     (red_res)
	);

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == T_IDLE);
	assign cmp_op    = (item_q.operation == OP_COMPARE);
	assign load_out  = (state_q == T_FIN) && (!out_valid_q || out_ready);
	assign red_start = accept || ((state_q == T_RED_A) && red_done && cmp_op);
	assign red_num   = (state_q == T_IDLE) ? in_data.num_a : item_q.num_b;
	assign red_den   = (state_q == T_IDLE) ? in_data.den_a : item_q.den_b;

	// one multiplier, used for each cross product in turn
	assign mul_x = (state_q == T_MUL_L) ? fa_q.num : fb_q.num;
	assign mul_y = (state_q == T_MUL_L) ? fb_q.den : fa_q.den;
	assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

	always_comb begin
		lneg  = fa_q.neg && lprod_q != '0;
		rneg  = fb_q.neg && rprod_q != '0;
		if (lneg != rneg) begin
			less = lneg;
		end else if (!lneg) begin
			less = lprod_q < rprod_q;
		end else begin
			less = rprod_q < lprod_q;
		end
		equal = (fa_q == fb_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= T_RED_A;
					end
				end
				T_RED_A: begin
					if (red_done) begin
						state_q <= cmp_op ? T_RED_B : T_FIN;
					end
				end
				T_RED_B: begin
					if (red_done) begin
						state_q <= T_MUL_L;
					end
				end
				T_MUL_L: state_q <= T_MUL_R;
				T_MUL_R: state_q <= T_FIN;
				T_FIN: begin
					if (load_out) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (state_q == T_RED_A && red_done) begin
			fa_q <= red_res;
		end
		if (state_q == T_RED_B && red_done) begin
			fb_q <= red_res;
		end
		if (state_q == T_MUL_L) begin
			lprod_q <= mul_p;
		end
		if (state_q == T_MUL_R) begin
			rprod_q <= mul_p;
		end
		if (load_out) begin
			out_data_q.reduced_num <= fa_q.neg ? W'(0) - fa_q.num : fa_q.num;
			out_data_q.reduced_den <= fa_q.den;
			out_data_q.is_less     <= cmp_op && less;
			out_data_q.is_equal    <= cmp_op && equal;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("top sequencer state not one-hot");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("ready still high after an item was taken");

	a_less_not_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.is_less) |-> !out_data.is_equal)
		else $error("result both less and equal");

	a_reduce_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !cmp_op) |=> !out_data.is_less && !out_data.is_equal)
		else $error("compare flags set in reduce mode");

endmodule

// File: tb/fraction_result_checker.sv
// ----------------------------------------------------------------------------
// fraction_result_checker: scoreboard of the fraction reduce/compare unit
// watches both channels, works out the reduced fraction and the compare
// flags of every accepted input item, and checks each returned item against
// the oldest outstanding prediction, field by field
// ----------------------------------------------------------------------------
module fraction_result_checker import frc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        mismatches,
	output int        outstanding
);

	out_item_t pending_results[$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s: got %0h, predicted %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// lowest terms by euclid, sign on the numerator, saturated as the unit does
	function automatic frac_t lowest_terms(logic signed [VALUE_WIDTH-1:0] n,
			logic signed [VALUE_WIDTH-1:0] d);
		logic [VALUE_WIDTH-1:0] n_abs, d_abs;
		logic [63:0] mn, md, x, y, r;
		frac_t f;
		n_abs = n[VALUE_WIDTH-1] ? -n : n;
		d_abs = d[VALUE_WIDTH-1] ? -d : d;
		mn = {{(64-VALUE_WIDTH){1'b0}}, n_abs};
		md = {{(64-VALUE_WIDTH){1'b0}}, d_abs};
		x = mn;
		y = md;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		if (x != 0) begin
			mn = mn / x;
			md = md / x;
		end
		f.neg = (n[VALUE_WIDTH-1] != d[VALUE_WIDTH-1]) && mn != 0 && md != 0;
		if (md > MAG_MAX)
			md = 64'(MAG_MAX);
		if (!f.neg && mn > MAG_MAX)
			mn = 64'(MAG_MAX);
		f.num = mn[VALUE_WIDTH-1:0];
		f.den = md[VALUE_WIDTH-2:0];
		return f;
	endfunction

	// exact cross products of the reduced fields
	function automatic logic below(frac_t p, frac_t q);
		logic [63:0] lhs, rhs;
		logic lneg, rneg;
		lhs = {{(64-VALUE_WIDTH){1'b0}}, p.num} * {{(65-VALUE_WIDTH){1'b0}}, q.den};
		rhs = {{(64-VALUE_WIDTH){1'b0}}, q.num} * {{(65-VALUE_WIDTH){1'b0}}, p.den};
		lneg = p.neg && lhs != 0;
		rneg = q.neg && rhs != 0;
		if (lneg != rneg)
			return lneg;
		if (!lneg)
			return lhs < rhs;
		return rhs < lhs;
	endfunction

	function automatic out_item_t reduce_compare(in_item_t it);
		frac_t fa, fb;
		out_item_t res;
		fa = lowest_terms(it.num_a, it.den_a);
		res.reduced_num = fa.neg ? -fa.num : fa.num;
		res.reduced_den = fa.den;
		res.is_less     = 1'b0;
		res.is_equal    = 1'b0;
		if (it.operation == OP_COMPARE) begin
			fb = lowest_terms(it.num_b, it.den_b);
			res.is_equal = (fa == fb);
			res.is_less  = below(fa, fb);
		end
		return res;
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with no item outstanding",
						64'(out_data.reduced_num), 64'(0));
				end else begin
					want = pending_results.pop_front();
					if (out_data.reduced_num !== want.reduced_num)
						report_mismatch("reduced_num", 64'(out_data.reduced_num),
							64'(want.reduced_num));
					if (out_data.reduced_den !== want.reduced_den)
						report_mismatch("reduced_den", 64'(out_data.reduced_den),
							64'(want.reduced_den));
					if (out_data.is_less !== want.is_less)
						report_mismatch("is_less", 64'(out_data.is_less),
							64'(want.is_less));
					if (out_data.is_equal !== want.is_equal)
						report_mismatch("is_equal", 64'(out_data.is_equal),
							64'(want.is_equal));
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(reduce_compare(in_data));
			outstanding <= pending_results.size();
		end
	end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the fraction reduce/compare unit
// directed items on the special fractions (zero and infinite values, signs,
// extreme magnitudes, wide cross products), then random reduce and compare
// items over four phases of sender idling and receiver back-pressure;
// a separate checker predicts and compares every returned item
// ----------------------------------------------------------------------------
module tb;
	import frc_pkg::*;

	localparam int     ITEMS_PER_PHASE = 225;
	localparam int     WATCHDOG_LIMIT  = 5000;
	localparam int     DRAIN_CYCLES    = 500;
	localparam longint MAG_LIMIT       = longint'(MAG_MAX);
	localparam int     TOPV            = MAG_MAX;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	int mismatches;
	int outstanding;
	int send_idle      = 0;
	int recv_stall     = 0;
	int stalled_cycles = 0;

	fraction_reduce_compare dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	fraction_result_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles == WATCHDOG_LIMIT) begin
			$display("[fraction_reduce_compare] ERROR");
			$finish;
		end
	end

	function automatic in_item_t make_item(op_t op, int na, int da, int nb, int db);
		in_item_t it;
		it.operation = op;
		it.num_a     = na;
		it.den_a     = da;
		it.num_b     = nb;
		it.den_b     = db;
		return it;
	endfunction

	function automatic int signed_pick(int unsigned lim);
		int v;
		v = $urandom_range(lim);
		return $urandom_range(1) ? -v : v;
	endfunction

	// full-width word, most negative value excluded
	function automatic logic signed [VALUE_WIDTH-1:0] any_word();
		logic [VALUE_WIDTH-1:0] v;
		v = $urandom;
		if (v == {1'b1, {(VALUE_WIDTH-1){1'b0}}})
			v = '1;
		return v;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int g;
		longint pn, pd;
		int unsigned k;
		it.operation = $urandom_range(1) ? OP_COMPARE : OP_REDUCE;
		case ($urandom_range(7))
			0: begin
				it.num_a = any_word();
				it.den_a = any_word();
			end
			1: begin
				it.num_a = signed_pick(20);
				it.den_a = signed_pick(20);
			end
			2: begin
				it.num_a = any_word();
				it.den_a = signed_pick(3);
				if ($urandom_range(1)) begin
					it.den_a = it.num_a;
					it.num_a = signed_pick(3);
				end
			end
			default: begin
				g = $urandom_range(1, 65535);
				it.num_a = g * signed_pick(32767);
				it.den_a = g * signed_pick(32767);
			end
		endcase
		case ($urandom_range(3))
			0: begin
				it.num_b = any_word();
				it.den_b = any_word();
			end
			1: begin
				g = $urandom_range(1, 65535);
				it.num_b = g * signed_pick(32767);
				it.den_b = g * signed_pick(32767);
			end
			2: begin
				// same value, scaled and possibly both signs flipped
				k  = $urandom_range(1, 4);
				pn = longint'(it.num_a) * k;
				pd = longint'(it.den_a) * k;
				if (pn > MAG_LIMIT || pn < -MAG_LIMIT || pd > MAG_LIMIT || pd < -MAG_LIMIT) begin
					pn = longint'(it.num_a);
					pd = longint'(it.den_a);
				end
				if ($urandom_range(1)) begin
					pn = -pn;
					pd = -pd;
				end
				it.num_b = pn[VALUE_WIDTH-1:0];
				it.den_b = pd[VALUE_WIDTH-1:0];
			end
			default: begin
				pn = longint'(it.num_a) + signed_pick(1);
				if (pn > MAG_LIMIT || pn < -MAG_LIMIT)
					pn = longint'(it.num_a);
				it.num_b = pn[VALUE_WIDTH-1:0];
				it.den_b = it.den_a;
			end
		endcase
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct);
		send_idle  = idle_pct;
		recv_stall = stall_pct;
		repeat (ITEMS_PER_PHASE)
			send_item(random_item());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(make_item(OP_REDUCE, 0, 0, -1, TOPV));
		send_item(make_item(OP_REDUCE, 5, 0, TOPV, -1));
		send_item(make_item(OP_REDUCE, -5, 0, 0, 0));
		send_item(make_item(OP_REDUCE, 0, -7, -TOPV, 1));
		send_item(make_item(OP_REDUCE, 6, 4, 3, 9));
		send_item(make_item(OP_REDUCE, -6, 4, 1, 1));
		send_item(make_item(OP_REDUCE, 6, -4, 1, 1));
		send_item(make_item(OP_REDUCE, -6, -4, 1, 1));
		send_item(make_item(OP_REDUCE, TOPV, TOPV, 2, 3));
		send_item(make_item(OP_REDUCE, -TOPV, 1, 2, 3));
		send_item(make_item(OP_REDUCE, 1, -TOPV, 2, 3));
		send_item(make_item(OP_REDUCE, TOPV - 1, -(TOPV / 2), 2, 3));
		send_item(make_item(OP_COMPARE, 2, 4, -1, -2));
		send_item(make_item(OP_COMPARE, -1, 2, 1, 3));
		send_item(make_item(OP_COMPARE, 1, 3, -1, 2));
		send_item(make_item(OP_COMPARE, 1, 0, 5, 1));
		send_item(make_item(OP_COMPARE, -3, 0, 7, 0));
		send_item(make_item(OP_COMPARE, 0, 0, 0, 0));
		send_item(make_item(OP_COMPARE, 0, 0, 1, 2));
		send_item(make_item(OP_COMPARE, 0, 5, 0, -9));
		send_item(make_item(OP_COMPARE, -TOPV, 1, TOPV, 1));
		send_item(make_item(OP_COMPARE, TOPV, TOPV - 1, TOPV - 1, TOPV - 2));
		send_item(make_item(OP_COMPARE, -TOPV, TOPV - 1, -(TOPV - 1), TOPV - 2));
		send_item(make_item(OP_COMPARE, 1, TOPV, 1, TOPV - 1));

		run_phase(0, 0);
		run_phase(50, 0);
		run_phase(0, 50);
		run_phase(26, 26);

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[fraction_reduce_compare] OK");
		else
			$display("[fraction_reduce_compare] ERROR");
		$finish;
	end

endmodule
